### rtl/core/nau_pkg.sv
package nau_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int RANGE_STEPS = 6;
    localparam int HORNER_TERMS = 14;
    localparam int DIV_STEPS   = 32;

    localparam logic [31:0] LN2_Q32       = 32'd2977044472;
    localparam logic [27:0] C_CUBIC_Q32   = 28'd192049463;
    localparam logic [31:0] SQRT_2_PI_Q32 = 32'd3426888095;
    localparam logic [32:0] Q32_ONE       = 33'h1_0000_0000;
    // exp(-t) is taken as zero from 33*ln2 upward.
    localparam logic [37:0] EXP_ZERO_T    = 38'd98242467576;

    typedef enum logic [3:0] {
        MODE_RELU     = 4'd0,
        MODE_CLIP     = 4'd1,
        MODE_GELU     = 4'd2,
        MODE_LEAKY    = 4'd3,
        MODE_TANH     = 4'd4,
        MODE_SIGMOID  = 4'd5,
        MODE_HSIGMOID = 4'd6,
        MODE_ELU      = 4'd7,
        MODE_NOOP     = 4'd8
    } t_mode;

    typedef struct packed {
        logic [31:0]              r;
        logic [32:0]              p;
        logic [5:0]               k;
        logic                     zero;
        logic signed [DATA_W-1:0] x;
    } t_hrn;

    typedef struct packed {
        logic [34:0]              rem;
        logic [33:0]              b;
        logic [31:0]              q;
        logic [32:0]              e;
        logic signed [DATA_W-1:0] x;
    } t_div;

    // Reciprocal 2^32/n, truncated, for the Horner divisors.
    function automatic logic [32:0] f_recip(input logic [3:0] n);
        logic [32:0] m;
        begin
            case (n)
                4'd1:    m = 33'd4294967296;
                4'd2:    m = 33'd2147483648;
                4'd3:    m = 33'd1431655765;
                4'd4:    m = 33'd1073741824;
                4'd5:    m = 33'd858993459;
                4'd6:    m = 33'd715827882;
                4'd7:    m = 33'd613566756;
                4'd8:    m = 33'd536870912;
                4'd9:    m = 33'd477218588;
                4'd10:   m = 33'd429496729;
                4'd11:   m = 33'd390451572;
                4'd12:   m = 33'd357913941;
                4'd13:   m = 33'd330382099;
                4'd14:   m = 33'd306783378;
                default: m = 33'd0;
            endcase
            return m;
        end
    endfunction

endpackage

### rtl/core/nau_front.sv
module nau_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic signed [nau_pkg::DATA_W-1:0] i_x,
    input  logic [3:0]                        i_mode,
    output logic                              o_vld,
    output nau_pkg::t_hrn                     o_hrn
);
    import nau_pkg::*;

    logic                     r_vp [1:6];
    logic signed [DATA_W-1:0] r_xp [1:6];
    logic [31:0]              r_mp [1:6];
    logic [37:0]              r_sq2;
    logic [40:0]              r_a3;
    logic [36:0]              r_cc;
    logic [37:0]              r_s5;
    logic [37:0]              r_u6;

    logic [37:0]              r_rt [0:RANGE_STEPS];
    logic [5:0]               r_rk [0:RANGE_STEPS];
    logic                     r_rz [0:RANGE_STEPS];
    logic signed [DATA_W-1:0] r_rx [0:RANGE_STEPS];
    logic                     r_rv [0:RANGE_STEPS];

    logic [37:0]              n_rt [1:RANGE_STEPS];
    logic [5:0]               n_rk [1:RANGE_STEPS];

    logic [31:0] n_m1;
    logic [56:0] n_cube;
    logic [68:0] n_cc;
    logic [69:0] n_u;
    logic [48:0] n_t;

    always_comb begin
        n_m1   = i_x[DATA_W-1] ? (32'd0 - 32'(i_x)) : 32'(i_x);
        n_cube = 57'(r_sq2) * 57'(r_mp[2][18:0]);
        n_cc   = 69'(r_a3) * 69'(C_CUBIC_Q32);
        n_u    = 70'(r_s5) * 70'(SQRT_2_PI_Q32);
        case (i_mode)
            MODE_GELU:             n_t = 49'({r_u6, 1'b0});
            MODE_TANH:             n_t = {r_mp[6], 17'd0};
            MODE_SIGMOID, MODE_ELU: n_t = 49'({r_mp[6], 16'd0});
            default:               n_t = 49'd0;
        endcase
    end

    always_comb begin
        logic [37:0] step;
        for (int i = 0; i < RANGE_STEPS; i++) begin
            step = 38'(LN2_Q32) << (RANGE_STEPS - 1 - i);
            if (r_rt[i] >= step) begin
                n_rt[i+1] = r_rt[i] - step;
                n_rk[i+1] = r_rk[i] | (6'd1 << (RANGE_STEPS - 1 - i));
            end else begin
                n_rt[i+1] = r_rt[i];
                n_rk[i+1] = r_rk[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= 6; i++) r_vp[i] <= 1'b0;
            for (int i = 0; i <= RANGE_STEPS; i++) r_rv[i] <= 1'b0;
        end else begin
            r_vp[1] <= i_vld;
            for (int i = 2; i <= 6; i++) r_vp[i] <= r_vp[i-1];
            r_rv[0] <= r_vp[6];
            for (int i = 1; i <= RANGE_STEPS; i++) r_rv[i] <= r_rv[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_xp[1] <= i_x;
        r_mp[1] <= n_m1;
        for (int i = 2; i <= 6; i++) r_xp[i] <= r_xp[i-1];
        for (int i = 2; i <= 6; i++) r_mp[i] <= r_mp[i-1];
        r_sq2 <= 38'(r_mp[1][18:0]) * 38'(r_mp[1][18:0]);
        r_a3  <= n_cube[56:16];
        r_cc  <= n_cc[68:32];
        r_s5  <= 38'({r_mp[4][18:0], 16'd0}) + 38'(r_cc);
        r_u6  <= n_u[69:32];
        r_rt[0] <= n_t[37:0];
        r_rk[0] <= 6'd0;
        r_rz[0] <= (n_t >= 49'(EXP_ZERO_T));
        r_rx[0] <= r_xp[6];
        for (int i = 1; i <= RANGE_STEPS; i++) begin
            r_rt[i] <= n_rt[i];
            r_rk[i] <= n_rk[i];
            r_rz[i] <= r_rz[i-1];
            r_rx[i] <= r_rx[i-1];
        end
    end

    always_comb begin
        o_vld       = r_rv[RANGE_STEPS];
        o_hrn.r     = r_rt[RANGE_STEPS][31:0];
        o_hrn.p     = Q32_ONE;
        o_hrn.k     = r_rk[RANGE_STEPS];
        o_hrn.zero  = r_rz[RANGE_STEPS];
        o_hrn.x     = r_rx[RANGE_STEPS];
    end

endmodule

### rtl/core/nau_horner_cell.sv
module nau_horner_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  nau_pkg::t_hrn i_d,
    input  logic [3:0]    i_div,
    output logic          o_vld,
    output nau_pkg::t_hrn o_d
);
    import nau_pkg::*;

    logic        r_v1, r_v2, r_v3;
    t_hrn        r_d1, r_d2, r_d3;
    logic [31:0] r_prod1;
    logic [31:0] r_val2;
    logic [31:0] r_q2;

    logic [64:0] n_rp;
    logic [65:0] n_w;
    logic [35:0] n_rem;
    logic [31:0] n_q;
    t_hrn        n_d3;

    always_comb begin
        n_rp  = 65'(i_d.r) * 65'(i_d.p);
        n_w   = 66'(r_prod1) * 66'(f_recip(i_div));
        n_rem = 36'(r_val2) - 36'(r_q2) * 36'(i_div);
        n_q   = (n_rem >= 36'(i_div)) ? (r_q2 + 32'd1) : r_q2;
        n_d3   = r_d2;
        n_d3.p = Q32_ONE - 33'(n_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1    <= i_d;
        r_prod1 <= n_rp[63:32];
        r_d2    <= r_d1;
        r_val2  <= r_prod1;
        r_q2    <= n_w[63:32];
        r_d3    <= n_d3;
    end

    assign o_vld = r_v3;
    assign o_d   = r_d3;

endmodule

### rtl/core/nau_div_cell.sv
module nau_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  nau_pkg::t_div i_d,
    output logic          o_vld,
    output nau_pkg::t_div o_d
);
    import nau_pkg::*;

    logic        r_vld;
    t_div        r_d;
    logic [34:0] n_rem2;
    t_div        n_d;

    always_comb begin
        n_rem2 = {i_d.rem[33:0], 1'b0};
        n_d    = i_d;
        if (n_rem2 >= 35'(i_d.b)) begin
            n_d.rem = n_rem2 - 35'(i_d.b);
            n_d.q   = {i_d.q[30:0], 1'b1};
        end else begin
            n_d.rem = n_rem2;
            n_d.q   = {i_d.q[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

### rtl/core/nau_back.sv
module nau_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  nau_pkg::t_div                     i_d,
    input  logic [3:0]                        i_mode,
    input  logic signed [nau_pkg::DATA_W-1:0] i_clip_limit,
    input  logic signed [nau_pkg::DATA_W-1:0] i_neg_slope,
    input  logic signed [nau_pkg::DATA_W-1:0] i_hs_alpha,
    input  logic signed [nau_pkg::DATA_W-1:0] i_hs_beta,
    output logic                              o_vld,
    output logic signed [nau_pkg::DATA_W-1:0] o_y
);
    import nau_pkg::*;

    localparam int Y_W = 50;

    logic                     r_v1, r_v2;
    logic signed [DATA_W-1:0] r_x;
    logic [31:0]              r_q;
    logic                     r_big;
    logic [50:0]              r_pg;
    logic [64:0]              r_pe;
    logic signed [63:0]       r_pl;
    logic signed [63:0]       r_ph;
    logic                     r_sneg;
    logic signed [DATA_W-1:0] r_y;

    logic [31:0]        n_m;
    logic [31:0]        n_smag;
    logic [32:0]        n_mm;
    logic signed [63:0] n_pl;
    logic signed [63:0] n_ph;

    always_comb begin
        n_m    = i_d.x[DATA_W-1] ? (32'd0 - 32'(i_d.x)) : 32'(i_d.x);
        n_smag = i_neg_slope[DATA_W-1] ? (32'd0 - 32'(i_neg_slope)) : 32'(i_neg_slope);
        n_mm   = Q32_ONE - i_d.e;
        n_pl   = 64'(i_d.x) * 64'(i_neg_slope);
        n_ph   = 64'(i_hs_alpha) * 64'(i_d.x);
    end

    always_ff @(posedge i_clk) begin
        r_x    <= i_d.x;
        r_q    <= i_d.q;
        r_big  <= |n_m[31:19];
        r_pg   <= 51'(n_m[18:0]) * 51'(i_d.q);
        r_pe   <= 65'(n_mm) * 65'(n_smag);
        r_pl   <= n_pl;
        r_ph   <= n_ph;
        r_sneg <= i_neg_slope[DATA_W-1];
    end

    logic                  neg;
    logic [19:0]           gm;
    logic [63:0]           lmag;
    logic [47:0]           lr;
    logic signed [63:0]    acc;
    logic [32:0]           accc;
    logic [17:0]           hr;
    logic [33:0]           em;
    logic [16:0]           tm;
    logic signed [DATA_W-1:0] clip;
    logic signed [Y_W-1:0] n_y;
    logic signed [DATA_W-1:0] n_sat;

    always_comb begin
        logic [35:0] gsum;
        logic [63:0] lsum;
        logic [33:0] hsum;
        logic [65:0] esum;
        logic [32:0] tsum;
        neg  = r_x[DATA_W-1];
        gsum = 36'(r_pg[50:16]) + 36'd32768;
        gm   = gsum[35:16];
        lmag = r_pl[63] ? (64'd0 - 64'(r_pl)) : 64'(r_pl);
        lsum = lmag + 64'd32768;
        lr   = lsum[63:16];
        acc  = r_ph + (64'(i_hs_beta) <<< FRAC_W);
        if (acc[63]) begin
            accc = 33'd0;
        end else if (acc > 64'sh1_0000_0000) begin
            accc = Q32_ONE;
        end else begin
            accc = acc[32:0];
        end
        hsum = 34'(accc) + 34'd32768;
        hr   = hsum[33:16];
        esum = 66'(r_pe) + 66'h8000_0000;
        em   = esum[65:32];
        tsum = 33'(r_q) + 33'd32768;
        tm   = tsum[32:16];
        clip = (r_x < i_clip_limit) ? r_x : i_clip_limit;

        case (i_mode)
            MODE_RELU:     n_y = neg ? Y_W'(0) : Y_W'(r_x);
            MODE_CLIP:     n_y = clip[DATA_W-1] ? Y_W'(0) : Y_W'(clip);
            MODE_GELU: begin
                if (r_big) begin
                    n_y = neg ? Y_W'(0) : Y_W'(r_x);
                end else begin
                    n_y = neg ? -$signed(Y_W'(gm)) : $signed(Y_W'(gm));
                end
            end
            MODE_LEAKY: begin
                if (neg) begin
                    n_y = r_pl[63] ? -$signed(Y_W'(lr)) : $signed(Y_W'(lr));
                end else begin
                    n_y = Y_W'(r_x);
                end
            end
            MODE_TANH:     n_y = neg ? -$signed(Y_W'(tm)) : $signed(Y_W'(tm));
            MODE_SIGMOID:  n_y = $signed(Y_W'(tm));
            MODE_HSIGMOID: n_y = $signed(Y_W'(hr));
            MODE_ELU: begin
                if (neg) begin
                    n_y = r_sneg ? $signed(Y_W'(em)) : -$signed(Y_W'(em));
                end else begin
                    n_y = Y_W'(r_x);
                end
            end
            default:       n_y = Y_W'(r_x);
        endcase

        if (n_y > $signed(Y_W'(32'h7FFF_FFFF))) begin
            n_sat = 32'sh7FFF_FFFF;
        end else if (n_y < -$signed(Y_W'(33'h1_0000_0000) >>> 1)) begin
            n_sat = 32'sh8000_0000;
        end else begin
            n_sat = n_y[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y <= n_sat;
    end

    assign o_vld = r_v2;
    assign o_y   = r_y;

endmodule

### rtl/core/neural_activation_unit.sv
// Channel   Direction  Handshake           Payload
// input     in         start / busy        i_sample_in
// result    out        o_done (strobe)     o_sample_out
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One word is accepted every cycle; busy stays low.
// Each result passes through the front end, the exp stages (14 Horner cells)
// and the 32-cell divider before the output stage.
// Reset is synchronous; it clears the pipeline valid bits and loads the config registers with defaults.
// The result is shown for one cycle with o_done and cannot be held off.
module neural_activation_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [nau_pkg::DATA_W-1:0] i_sample_in,
    output logic                              o_done,
    output logic signed [nau_pkg::DATA_W-1:0] o_sample_out,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_idx,
    input  logic [nau_pkg::DATA_W-1:0]        i_cfg_data
);
    import nau_pkg::*;

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_CLIP  = 3'd1;
    localparam logic [2:0] CFG_SLOPE = 3'd2;
    localparam logic [2:0] CFG_ALPHA = 3'd3;
    localparam logic [2:0] CFG_BETA  = 3'd4;

    logic [3:0]               r_mode;
    logic signed [DATA_W-1:0] r_clip_limit;
    logic signed [DATA_W-1:0] r_neg_slope;
    logic signed [DATA_W-1:0] r_hs_alpha;
    logic signed [DATA_W-1:0] r_hs_beta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_RELU;
            r_clip_limit <= 32'sd393216;
            r_neg_slope  <= 32'sd0;
            r_hs_alpha   <= 32'sd13107;
            r_hs_beta    <= 32'sd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  r_mode       <= i_cfg_data[3:0];
                CFG_CLIP:  r_clip_limit <= i_cfg_data;
                CFG_SLOPE: r_neg_slope  <= i_cfg_data;
                CFG_ALPHA: r_hs_alpha   <= i_cfg_data;
                CFG_BETA:  r_hs_beta    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic w_hv [0:HORNER_TERMS];
    t_hrn w_hrn [0:HORNER_TERMS];

    nau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start & ~busy),
        .i_x     (i_sample_in),
        .i_mode  (r_mode),
        .o_vld   (w_hv[0]),
        .o_hrn   (w_hrn[0])
    );

    for (genvar i = 0; i < HORNER_TERMS; i++) begin : g_hrn
        nau_horner_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_hv[i]),
            .i_d     (w_hrn[i]),
            .i_div   (4'(HORNER_TERMS - i)),
            .o_vld   (w_hv[i+1]),
            .o_d     (w_hrn[i+1])
        );
    end

    logic        r_dv0;
    t_div        r_d0;
    logic [32:0] n_e;
    logic [32:0] n_num;
    t_div        n_d0;

    always_comb begin
        n_e = w_hrn[HORNER_TERMS].zero ? 33'd0
                                       : (w_hrn[HORNER_TERMS].p >> w_hrn[HORNER_TERMS].k);
        case (r_mode)
            MODE_TANH:              n_num = Q32_ONE - n_e;
            MODE_GELU, MODE_SIGMOID: n_num = w_hrn[HORNER_TERMS].x[DATA_W-1] ? n_e : Q32_ONE;
            default:                n_num = 33'd0;
        endcase
        n_d0.rem = 35'(n_num);
        n_d0.b   = 34'(Q32_ONE) + 34'(n_e);
        n_d0.q   = 32'd0;
        n_d0.e   = n_e;
        n_d0.x   = w_hrn[HORNER_TERMS].x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv0 <= 1'b0;
        end else begin
            r_dv0 <= w_hv[HORNER_TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
    end

    logic w_dv [0:DIV_STEPS];
    t_div w_dd [0:DIV_STEPS];

    assign w_dv[0] = r_dv0;
    assign w_dd[0] = r_d0;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        nau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_dv[i]),
            .i_d     (w_dd[i]),
            .o_vld   (w_dv[i+1]),
            .o_d     (w_dd[i+1])
        );
    end

    nau_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (w_dv[DIV_STEPS]),
        .i_d          (w_dd[DIV_STEPS]),
        .i_mode       (r_mode),
        .i_clip_limit (r_clip_limit),
        .i_neg_slope  (r_neg_slope),
        .i_hs_alpha   (r_hs_alpha),
        .i_hs_beta    (r_hs_beta),
        .o_vld        (o_done),
        .o_y          (o_sample_out)
    );

endmodule

### sim/neural_activation_unit_tb.sv
module neural_activation_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nau_pkg::*;

    class activation_scoreboard;
        t_mode       mode;
        logic [31:0] clip_limit;
        logic [31:0] neg_slope;
        logic [31:0] hs_alpha;
        logic [31:0] hs_beta;
        longint      expected_samples[$];
        bit          approx_flags[$];
        int          errors;

        function void restore_defaults();
            mode       = MODE_RELU;
            clip_limit = 32'd393216;
            neg_slope  = 32'd0;
            hs_alpha   = 32'd13107;
            hs_beta    = 32'd32768;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                3'd0: mode = t_mode'(data[3:0]);
                3'd1: clip_limit = data;
                3'd2: neg_slope = data;
                3'd3: hs_alpha = data;
                3'd4: hs_beta = data;
                default: ;
            endcase
        endfunction

        function bit [63:0] mul_hi(bit [63:0] a, bit [63:0] b);
            bit [63:0] ah, al, bh, bl;
            ah = a >> 32;
            al = a & 64'hFFFF_FFFF;
            bh = b >> 32;
            bl = b & 64'hFFFF_FFFF;
            return ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
        endfunction

        function bit [63:0] frac_div(bit [63:0] num, bit [63:0] den);
            bit [63:0] rem, quo;
            rem = num;
            quo = 0;
            for (int i = 0; i < 32; i++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    quo = quo | 1;
                end
            end
            return quo;
        endfunction

        function bit [63:0] exp_decay(bit [63:0] t);
            bit [63:0] k, r, p;
            if (t >= (64'd64 << 32))
                return 0;
            k = t / 64'(LN2_Q32);
            if (k > 32)
                return 0;
            r = t - k * 64'(LN2_Q32);
            p = 64'(Q32_ONE);
            for (int n = 14; n >= 1; n--)
                p = 64'(Q32_ONE) - ((r * p) >> 32) / 64'(n);
            return p >> k;
        endfunction

        function bit [63:0] to_sample(bit [63:0] m);
            return (m + (64'd1 << (31 - FRAC_W))) >> (32 - FRAC_W);
        endfunction

        function longint signed_mag(bit [63:0] m, bit neg);
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function longint round_shift(longint p);
            bit        neg;
            bit [63:0] m;
            neg = p < 0;
            m = neg ? 64'(-p) : 64'(p);
            m = (m + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
            return signed_mag(m, neg);
        endfunction

        function longint activate(logic signed [31:0] sample);
            longint    x, y, lim, acc, s;
            bit        neg, sneg;
            bit [63:0] a, e, m, u, smag;
            x = sample;
            neg = x < 0;
            a = (neg ? 64'(-x) : 64'(x)) << (32 - FRAC_W);
            y = x;
            case (mode)
                MODE_RELU: y = neg ? 0 : x;
                MODE_CLIP: begin
                    lim = longint'(signed'(clip_limit));
                    y = x < lim ? x : lim;
                    if (y < 0)
                        y = 0;
                end
                MODE_GELU: begin
                    if (a >= (64'd8 << 32)) begin
                        y = neg ? 0 : x;
                    end else begin
                        u = mul_hi(mul_hi(a, a), a);
                        u = mul_hi(a + mul_hi(u, 64'(C_CUBIC_Q32)), 64'(SQRT_2_PI_Q32));
                        e = exp_decay(u << 1);
                        m = neg ? frac_div(e, 64'(Q32_ONE) + e)
                                : frac_div(64'(Q32_ONE), 64'(Q32_ONE) + e);
                        y = signed_mag(to_sample(mul_hi(a, m)), neg);
                    end
                end
                MODE_LEAKY: y = neg ? round_shift(x * longint'(signed'(neg_slope))) : x;
                MODE_TANH: begin
                    e = exp_decay(a << 1);
                    m = frac_div(64'(Q32_ONE) - e, 64'(Q32_ONE) + e);
                    y = signed_mag(to_sample(m), neg);
                end
                MODE_SIGMOID: begin
                    e = exp_decay(a);
                    m = neg ? frac_div(e, 64'(Q32_ONE) + e)
                            : frac_div(64'(Q32_ONE), 64'(Q32_ONE) + e);
                    y = longint'(to_sample(m));
                end
                MODE_HSIGMOID: begin
                    acc = longint'(signed'(hs_alpha)) * x
                        + longint'(signed'(hs_beta)) * (longint'(1) << FRAC_W);
                    if (acc < 0)
                        acc = 0;
                    if (acc > (longint'(1) << (2 * FRAC_W)))
                        acc = longint'(1) << (2 * FRAC_W);
                    y = round_shift(acc);
                end
                MODE_ELU: begin
                    if (neg) begin
                        s = longint'(signed'(neg_slope));
                        sneg = s < 0;
                        smag = sneg ? 64'(-s) : 64'(s);
                        m = 64'(Q32_ONE) - exp_decay(a);
                        m = (m * smag + (64'd1 << 31)) >> 32;
                        y = signed_mag(m, !sneg);
                    end
                end
                default: y = x;
            endcase
            if (y > 64'sd2147483647)
                y = 64'sd2147483647;
            if (y < -64'sd2147483648)
                y = -64'sd2147483648;
            return y;
        endfunction

        function void note_input(logic signed [31:0] sample);
            expected_samples.push_back(activate(sample));
            approx_flags.push_back(mode inside {MODE_GELU, MODE_TANH, MODE_SIGMOID, MODE_ELU});
        endfunction

        function void check_result(logic signed [31:0] actual);
            longint want, diff;
            bit     approx;
            if (expected_samples.size() == 0) begin
                $error("sample_out: unexpected word, actual %0d", actual);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            approx = approx_flags.pop_front();
            diff = want - longint'(actual);
            if (diff < 0)
                diff = -diff;
            if ($isunknown(actual) || diff > (approx ? 2 : 0)) begin
                $error("sample_out: expected %0d actual %0d", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] i_sample_in;
    logic                     o_done;
    logic signed [DATA_W-1:0] o_sample_out;
    logic                     i_cfg_we;
    logic [2:0]               i_cfg_idx;
    logic [DATA_W-1:0]        i_cfg_data;

    activation_scoreboard board;
    int                       burst_left;

    neural_activation_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_sample_in  (i_sample_in),
        .o_done       (o_done),
        .o_sample_out (o_sample_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            board.check_result(o_sample_out);
    end

    task automatic send_word(logic signed [31:0] sample);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0)
                burst_left = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_sample_in <= sample;
        do
            @(posedge i_clk);
        while (busy);
        board.note_input(sample);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (board.expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_param(bit extreme);
        case (extreme ? $urandom_range(0, 5) : 6 + $urandom_range(0, 2))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0001_0000;
            5: return $urandom();
            6: return $urandom_range(0, 32'h0002_0000);
            7: return -$urandom_range(0, 32'h0002_0000);
            default: return $urandom_range(0, 32'h000A_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h000A_0000);
            2: return -$urandom_range(0, 32'h000A_0000);
            3: return $urandom_range(0, 32'h0000_4000) - 32'h2000;
            4: return ($urandom() & 32'h001F_FFFF) | ($urandom_range(0, 1) ? 32'hFFE0_0000 : 0);
            default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7FFF_FFFF} ^ $urandom_range(0, 3);
        endcase
    endfunction

    logic [31:0] corner_samples[$] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h0001_0000, 32'hFFFF_0000, 32'h0008_0000, 32'hFFF8_0000, 32'h0007_FFFF,
        32'hFFF8_0001, 32'h0040_0000, 32'hFFC0_0000, 32'h0000_8000, 32'hFFFF_8000,
        32'h0020_0000, 32'hFFE0_0000
    };

    initial begin
        board = new();
        board.restore_defaults();
        burst_left = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_sample_in <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_samples[i])
            send_word(corner_samples[i]);
        wait_idle();

        for (int phase = 0; phase < 36; phase++) begin
            if (phase < 16)
                write_reg(3'd0, phase);
            else
                write_reg(3'd0, $urandom_range(0, 15));
            for (int r = 1; r <= 4; r++)
                write_reg(r[2:0], pick_param(phase % 3 == 0));
            write_reg(3'($urandom_range(5, 7)), $urandom());
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
            if (phase < 10)
                foreach (corner_samples[i])
                    send_word(corner_samples[i]);
            repeat ($urandom_range(26, 56))
                send_word(pick_sample());
            wait_idle();
        end

        while (board.expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
